// ----- src/hwe_pkg.sv -----
// ----------------------------------------------------------------------------
// hwe_pkg: shared types and constants
// Holds the controller states, datapath operations and fixed widths of the
// Hardy-Weinberg exact test core.
// ----------------------------------------------------------------------------
package hwe_pkg;

    localparam int CNT_W   = 13;   // genotype count fields
    localparam int N_W     = 15;   // sum of three counts
    localparam int AL_W    = 16;   // allele and heterozygote counts
    localparam int SAMP_W  = 17;   // width able to hold the sample limit
    localparam int FAC_W   = 34;   // recurrence numerator and denominator
    localparam int W_W     = 64;   // Q24.40 weight
    localparam int PP_W    = 66;   // one 32-bit half of a weight times a factor
    localparam int PROD_W  = 98;   // full weight times factor
    localparam int SUM_W   = 80;   // exact weight sums
    localparam int DIV_W   = 112;  // divider dividend register
    localparam int IT_W    = 7;    // divider iteration counter
    localparam int P_W     = 32;
    localparam int ST_W    = 2;

    localparam logic [W_W-1:0] START_WEIGHT = 64'd100 << 40;
    localparam logic [P_W-1:0] P_NOT_COMPUTABLE = 32'h8000_0000;

    localparam logic [IT_W-1:0] IT_INIT  = 7'd32;
    localparam logic [IT_W-1:0] IT_SCALE = 7'd98;
    localparam logic [IT_W-1:0] IT_FINAL = 7'd110;

    localparam logic [ST_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [ST_W-1:0] STATUS_NO_SAMPLES = 2'd1;
    localparam logic [ST_W-1:0] STATUS_OVERSIZE   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_SPECIAL, ST_PROD, ST_DIV0, ST_DIV0_WAIT, ST_ADJ, ST_AB,
        ST_DN_TEST, ST_DN_NUM, ST_DN_MLO, ST_DN_MHI, ST_DN_DIV, ST_DN_WAIT, ST_DN_WR,
        ST_UP_INIT, ST_UP_TEST, ST_UP_NUM, ST_UP_MLO, ST_UP_MHI, ST_UP_DIV, ST_UP_WAIT,
        ST_UP_WR, ST_OBS_RD, ST_OBS_LATCH, ST_SUM_RD, ST_SUM_ACC, ST_FIN_DIV,
        ST_FIN_WAIT, ST_FINISH, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SPECIAL, OP_PROD, OP_DIV_INIT, OP_ADJ, OP_AB,
        OP_DN_NUM, OP_UP_INIT, OP_UP_NUM, OP_MUL_LO, OP_MUL_HI, OP_DIV_SCALE,
        OP_DN_WR, OP_UP_WR, OP_OBS_RD, OP_OBS_LATCH, OP_SUM_RD, OP_SUM_ACC,
        OP_DIV_FIN, OP_RESULT
    } dp_op_t;

    typedef struct packed {
        logic no_samples;
        logic oversize;
        logic div_done;
        logic dn_more;
        logic up_more;
        logic sum_last;
    } dp_status_t;

endpackage

// ----- src/hwe_exact_test_core.sv -----
// Flow: for no samples or an oversized count sum the controller goes from the
//   check state through the special state to the result strobe; otherwise it
//   runs both weight sweeps, and each weight step waits on the one-bit-a-cycle
//   divider.
// Throughput: one transfer at a time; start is taken only while busy is low,
//   which is again the case in the cycle after the result strobe.
// Reset: rst_n clears the controller asynchronously; the weight store is not
//   cleared, since every entry is written before it is read for an item.
// ----------------------------------------------------------------------------
// hwe_exact_test_core: Hardy-Weinberg exact test
// Takes three genotype counts per transfer and returns the exact test p-value
// in Q2.30 together with a status code.
// ----------------------------------------------------------------------------
module hwe_exact_test_core #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    output logic                      done,
    input  logic [hwe_pkg::CNT_W-1:0] hom_major_count,
    input  logic [hwe_pkg::CNT_W-1:0] het_count,
    input  logic [hwe_pkg::CNT_W-1:0] hom_minor_count,
    output logic [hwe_pkg::P_W-1:0]   p_value,
    output logic [hwe_pkg::ST_W-1:0]  status
);
    import hwe_pkg::*;

    // The controller issues one datapath operation per cycle and watches a
    // small set of status flags; the two share nothing else.
    dp_op_t     dp_op;
    dp_status_t dp_status;

    hwe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .dp_op     (dp_op),
        .busy      (busy),
        .done      (done)
    );

    // The datapath latches the counts on the accepting edge, sweeps the
    // weights down and then up from the starting heterozygote count, sums
    // them in one pass and divides the partial sum by the total. The result
    // registers hold steady while done is high for its single cycle.
    hwe_dpath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_op           (dp_op),
        .hom_major_count (hom_major_count),
        .het_count       (het_count),
        .hom_minor_count (hom_minor_count),
        .dp_status       (dp_status),
        .p_value         (p_value),
        .status          (status)
    );

endmodule

// ----- src/hwe_ctrl.sv -----
// ----------------------------------------------------------------------------
// hwe_ctrl: sequencing state machine
// Steps the datapath through set-up, both recurrence sweeps, the summing
// pass and the final division.
// ----------------------------------------------------------------------------
module hwe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  hwe_pkg::dp_status_t dp_status,
    output hwe_pkg::dp_op_t     dp_op,
    output logic                busy,
    output logic                done
);
    import hwe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (start) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (dp_status.no_samples || dp_status.oversize)
                    state_next = ST_SPECIAL;
                else
                    state_next = ST_PROD;
            end
            ST_SPECIAL:   state_next = ST_DONE;
            ST_PROD:      state_next = ST_DIV0;
            ST_DIV0:      state_next = ST_DIV0_WAIT;
            ST_DIV0_WAIT: if (dp_status.div_done) state_next = ST_ADJ;
            ST_ADJ:       state_next = ST_AB;
            ST_AB:        state_next = ST_DN_TEST;
            ST_DN_TEST:   state_next = dp_status.dn_more ? ST_DN_NUM : ST_UP_INIT;
            ST_DN_NUM:    state_next = ST_DN_MLO;
            ST_DN_MLO:    state_next = ST_DN_MHI;
            ST_DN_MHI:    state_next = ST_DN_DIV;
            ST_DN_DIV:    state_next = ST_DN_WAIT;
            ST_DN_WAIT:   if (dp_status.div_done) state_next = ST_DN_WR;
            ST_DN_WR:     state_next = ST_DN_TEST;
            ST_UP_INIT:   state_next = ST_UP_TEST;
            ST_UP_TEST:   state_next = dp_status.up_more ? ST_UP_NUM : ST_OBS_RD;
            ST_UP_NUM:    state_next = ST_UP_MLO;
            ST_UP_MLO:    state_next = ST_UP_MHI;
            ST_UP_MHI:    state_next = ST_UP_DIV;
            ST_UP_DIV:    state_next = ST_UP_WAIT;
            ST_UP_WAIT:   if (dp_status.div_done) state_next = ST_UP_WR;
            ST_UP_WR:     state_next = ST_UP_TEST;
            ST_OBS_RD:    state_next = ST_OBS_LATCH;
            ST_OBS_LATCH: state_next = ST_SUM_RD;
            ST_SUM_RD:    state_next = ST_SUM_ACC;
            ST_SUM_ACC:   state_next = dp_status.sum_last ? ST_FIN_DIV : ST_SUM_RD;
            ST_FIN_DIV:   state_next = ST_FIN_WAIT;
            ST_FIN_WAIT:  if (dp_status.div_done) state_next = ST_FINISH;
            ST_FINISH:    state_next = ST_DONE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        dp_op = OP_NONE;
        unique case (state_reg)
            ST_IDLE:      if (start) dp_op = OP_LOAD;
            ST_SPECIAL:   dp_op = OP_SPECIAL;
            ST_PROD:      dp_op = OP_PROD;
            ST_DIV0:      dp_op = OP_DIV_INIT;
            ST_ADJ:       dp_op = OP_ADJ;
            ST_AB:        dp_op = OP_AB;
            ST_DN_NUM:    dp_op = OP_DN_NUM;
            ST_DN_MLO:    dp_op = OP_MUL_LO;
            ST_DN_MHI:    dp_op = OP_MUL_HI;
            ST_DN_DIV:    dp_op = OP_DIV_SCALE;
            ST_DN_WR:     dp_op = OP_DN_WR;
            ST_UP_INIT:   dp_op = OP_UP_INIT;
            ST_UP_NUM:    dp_op = OP_UP_NUM;
            ST_UP_MLO:    dp_op = OP_MUL_LO;
            ST_UP_MHI:    dp_op = OP_MUL_HI;
            ST_UP_DIV:    dp_op = OP_DIV_SCALE;
            ST_UP_WR:     dp_op = OP_UP_WR;
            ST_OBS_RD:    dp_op = OP_OBS_RD;
            ST_OBS_LATCH: dp_op = OP_OBS_LATCH;
            ST_SUM_RD:    dp_op = OP_SUM_RD;
            ST_SUM_ACC:   dp_op = OP_SUM_ACC;
            ST_FIN_DIV:   dp_op = OP_DIV_FIN;
            ST_FINISH:    dp_op = OP_RESULT;
            default:      dp_op = OP_NONE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

// ----- src/hwe_dpath.sv -----
// ----------------------------------------------------------------------------
// hwe_dpath: arithmetic datapath
// Holds the counts, the weight store, a split multiplier and a shared
// one-bit-a-cycle restoring divider.
// ----------------------------------------------------------------------------
module hwe_dpath #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hwe_pkg::dp_op_t              dp_op,
    input  logic [hwe_pkg::CNT_W-1:0]    hom_major_count,
    input  logic [hwe_pkg::CNT_W-1:0]    het_count,
    input  logic [hwe_pkg::CNT_W-1:0]    hom_minor_count,
    output hwe_pkg::dp_status_t          dp_status,
    output logic [hwe_pkg::P_W-1:0]      p_value,
    output logic [hwe_pkg::ST_W-1:0]     status
);
    import hwe_pkg::*;

    localparam int STORE_DEPTH = MAX_SAMPLES / 2 + 4;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam logic [SAMP_W-1:0] MAX_LIM = SAMP_W'(MAX_SAMPLES);

    logic [CNT_W-1:0]  pq_reg;
    logic [N_W-1:0]    n_reg;
    logic [AL_W-1:0]   num_a_reg, num_b_reg;
    logic [AL_W-1:0]   init_reg, ab_reg, aa_reg, bb_reg, aa0_reg, bb0_reg;
    logic [W_W-1:0]    w_reg, obs_reg;
    logic [FAC_W-1:0]  num_reg, den_reg;
    logic [PP_W-1:0]   plo_reg, phi_reg;
    logic [SUM_W-1:0]  total_reg, part_reg;
    logic [ADDR_W-1:0] k_reg, top_reg;
    logic [P_W-1:0]    p_reg;
    logic [ST_W-1:0]   status_reg;

    // Divider state.
    logic              div_run_reg, div_done_reg;
    logic [IT_W-1:0]   div_cnt_reg;
    logic [DIV_W-1:0]  dq_reg;
    logic [SUM_W-1:0]  rem_reg, dvs_reg;
    logic [SUM_W:0]    rem_sh;
    logic              q_bit;

    // Weight store.
    logic [W_W-1:0]    mem [STORE_DEPTH];
    logic [W_W-1:0]    rd_data;
    logic              we;
    logic [ADDR_W-1:0] wa, ra;
    logic [W_W-1:0]    wd;

    logic [N_W-1:0]    n_in;
    logic [AL_W-1:0]   q0, init_adj, ab_dn, ab_up;
    logic [W_W-1:0]    sat_q;
    logic [PROD_W-1:0] prod;

    assign n_in = N_W'(hom_major_count) + N_W'(het_count) + N_W'(hom_minor_count);
    assign q0 = dq_reg[AL_W-1:0];
    assign init_adj = q0 + AL_W'(q0[0] ^ num_a_reg[0]);
    assign sat_q = (|dq_reg[PROD_W-1:W_W]) ? '1 : dq_reg[W_W-1:0];
    assign prod = {phi_reg, 32'd0} + PROD_W'(plo_reg);
    assign ab_dn = ab_reg - AL_W'(2);
    assign ab_up = ab_reg + AL_W'(2);

    assign rem_sh = {rem_reg, dq_reg[DIV_W-1]};
    assign q_bit = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        we = 1'b0;
        wa = ADDR_W'(ab_reg >> 1);
        wd = START_WEIGHT;
        ra = k_reg;
        unique case (dp_op)
            OP_AB:
            begin
                we = 1'b1;
            end
            OP_DN_WR:
            begin
                we = 1'b1;
                wa = ADDR_W'(ab_dn >> 1);
                wd = sat_q;
            end
            OP_UP_WR:
            begin
                we = 1'b1;
                wa = ADDR_W'(ab_up >> 1);
                wd = sat_q;
            end
            OP_OBS_RD:
            begin
                ra = ADDR_W'(pq_reg >> 1);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_run_reg  <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (dp_op == OP_DIV_INIT || dp_op == OP_DIV_SCALE || dp_op == OP_DIV_FIN)
            begin
                div_run_reg <= 1'b1;
                unique case (dp_op)
                    OP_DIV_INIT:  div_cnt_reg <= IT_INIT;
                    OP_DIV_SCALE: div_cnt_reg <= IT_SCALE;
                    default:      div_cnt_reg <= IT_FINAL;
                endcase
            end
            else if (div_run_reg)
            begin
                div_cnt_reg <= div_cnt_reg - IT_W'(1);
                if (div_cnt_reg == IT_W'(1))
                begin
                    div_run_reg  <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (dp_op)
            OP_DIV_INIT:
            begin
                dq_reg  <= {32'(num_a_reg) * 32'(num_b_reg), 80'd0};
                dvs_reg <= SUM_W'({n_reg, 1'b0});
                rem_reg <= '0;
            end
            OP_DIV_SCALE:
            begin
                dq_reg  <= {prod, 14'd0};
                dvs_reg <= SUM_W'(den_reg);
                rem_reg <= '0;
            end
            OP_DIV_FIN:
            begin
                dq_reg  <= {part_reg, 32'd0};
                dvs_reg <= total_reg;
                rem_reg <= '0;
            end
            default:
            begin
                if (div_run_reg)
                begin
                    dq_reg  <= {dq_reg[DIV_W-2:0], q_bit};
                    rem_reg <= q_bit ? SUM_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[SUM_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (dp_op)
            OP_LOAD:
            begin
                pq_reg    <= het_count;
                n_reg     <= n_in;
                num_a_reg <= {hom_major_count, 1'b0} + AL_W'(het_count);
                num_b_reg <= {hom_minor_count, 1'b0} + AL_W'(het_count);
            end
            OP_SPECIAL:
            begin
                p_reg      <= P_NOT_COMPUTABLE;
                status_reg <= (n_reg == '0) ? STATUS_NO_SAMPLES : STATUS_OVERSIZE;
            end
            OP_ADJ:
            begin
                init_reg <= init_adj;
                ab_reg   <= init_adj;
            end
            OP_AB:
            begin
                aa_reg  <= (num_a_reg - ab_reg) >> 1;
                bb_reg  <= (num_b_reg - ab_reg) >> 1;
                aa0_reg <= (num_a_reg - ab_reg) >> 1;
                bb0_reg <= (num_b_reg - ab_reg) >> 1;
                w_reg   <= START_WEIGHT;
            end
            OP_DN_NUM:
            begin
                // Going down uses aa_reg/bb_reg as the growing homozygote counts.
                num_reg <= FAC_W'(ab_reg) * FAC_W'(ab_reg - AL_W'(1));
                den_reg <= ((FAC_W'(aa_reg) + FAC_W'(1)) * (FAC_W'(bb_reg) + FAC_W'(1))) << 2;
            end
            OP_UP_INIT:
            begin
                w_reg  <= START_WEIGHT;
                ab_reg <= init_reg;
                aa_reg <= aa0_reg;
                bb_reg <= bb0_reg;
            end
            OP_UP_NUM:
            begin
                num_reg <= (FAC_W'(aa_reg) * FAC_W'(bb_reg)) << 2;
                den_reg <= (FAC_W'(ab_reg) + FAC_W'(2)) * (FAC_W'(ab_reg) + FAC_W'(1));
            end
            OP_MUL_LO: plo_reg <= w_reg[31:0] * num_reg;
            OP_MUL_HI: phi_reg <= w_reg[63:32] * num_reg;
            OP_DN_WR:
            begin
                w_reg  <= sat_q;
                ab_reg <= ab_dn;
                aa_reg <= aa_reg + AL_W'(1);
                bb_reg <= bb_reg + AL_W'(1);
            end
            OP_UP_WR:
            begin
                w_reg  <= sat_q;
                ab_reg <= ab_up;
                aa_reg <= aa_reg - AL_W'(1);
                bb_reg <= bb_reg - AL_W'(1);
            end
            OP_OBS_RD:
            begin
                top_reg <= ADDR_W'(ab_reg >> 1);
            end
            OP_OBS_LATCH:
            begin
                obs_reg   <= rd_data;
                k_reg     <= '0;
                total_reg <= '0;
                part_reg  <= '0;
            end
            OP_SUM_ACC:
            begin
                total_reg <= total_reg + SUM_W'(rd_data);
                if (rd_data <= obs_reg)
                    part_reg <= part_reg + SUM_W'(rd_data);
                k_reg <= k_reg + ADDR_W'(1);
            end
            OP_RESULT:
            begin
                p_reg      <= dq_reg[P_W-1:0];
                status_reg <= STATUS_OK;
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign dp_status.no_samples = (n_reg == '0);
    assign dp_status.oversize   = (SAMP_W'(n_reg) > MAX_LIM);
    assign dp_status.div_done   = div_done_reg;
    assign dp_status.dn_more    = (ab_reg >= AL_W'(2));
    assign dp_status.up_more    = (aa_reg != '0) && (bb_reg != '0);
    assign dp_status.sum_last   = (k_reg == top_reg);

    assign p_value = p_reg;
    assign status  = status_reg;

endmodule

// ----- src/hwe_checker.sv -----
// ----------------------------------------------------------------------------
// hwe_checker: port-level assertions
// Checks the command handshake and the shape of results on the top level.
// ----------------------------------------------------------------------------
module hwe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] p_value,
    input logic [1:0]  status
);
    import hwe_pkg::*;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done seen while idle");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done)) else $error("transfer not taken");

    a_special: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (p_value == P_NOT_COMPUTABLE))
        else $error("special case without 2.0");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_OK) |-> (p_value <= 32'h4000_0000))
        else $error("p-value above one");

endmodule

bind hwe_exact_test_core hwe_checker u_hwe_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .p_value (p_value),
    .status  (status)
);
